@@ hw/rtl/dfdm_pkg.sv @@
// Shared types and constants for the flow-direction mask block.
`timescale 1ns / 1ps
`default_nettype none

package dfdm_pkg;

    // Number of compass directions, bit 0 north, then clockwise.
    localparam int NUM_DIRS = 8;

    localparam int DIR_N  = 0;
    localparam int DIR_NE = 1;
    localparam int DIR_E  = 2;
    localparam int DIR_SE = 3;
    localparam int DIR_S  = 4;
    localparam int DIR_SW = 5;
    localparam int DIR_W  = 6;
    localparam int DIR_NW = 7;

    // Fixed widths of the configuration registers.
    localparam int GRID_BITS   = 16;
    localparam int THRESH_BITS = 32;

    // Configuration bus.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_DEPTH = 4;

    typedef enum logic [1:0] {
        METHOD_CROSS  = 2'd0,
        METHOD_DIRECT = 2'd1,
        METHOD_LOWEST = 2'd2,
        METHOD_DUMMY  = 2'd3
    } slope_method_t;

    typedef enum logic [1:0] {
        REG_SLOPE_METHOD     = 2'd0,
        REG_GRID_COLUMNS     = 2'd1,
        REG_GRID_ROWS        = 2'd2,
        REG_NODATA_THRESHOLD = 2'd3
    } reg_index_t;

    localparam logic [GRID_BITS-1:0]          GRID_COLUMNS_RESET = 16'd1;
    localparam logic [GRID_BITS-1:0]          GRID_ROWS_RESET    = 16'd1;
    localparam logic signed [THRESH_BITS-1:0] NODATA_RESET       = -32'sd128000;

    typedef struct packed {
        slope_method_t                  slope_method;
        logic [GRID_BITS-1:0]           grid_columns;
        logic [GRID_BITS-1:0]           grid_rows;
        logic signed [THRESH_BITS-1:0]  nodata_threshold;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/dfdm_apb_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module dfdm_apb_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dfdm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [dfdm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [dfdm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output dfdm_pkg::cfg_t                       cfg
);
    import dfdm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_SLOPE_METHOD:
                    cfg_next.slope_method = slope_method_t'(pwdata[1:0]);
                REG_GRID_COLUMNS:
                    cfg_next.grid_columns = pwdata[GRID_BITS-1:0];
                REG_GRID_ROWS:
                    cfg_next.grid_rows = pwdata[GRID_BITS-1:0];
                REG_NODATA_THRESHOLD:
                    cfg_next.nodata_threshold = $signed(pwdata[THRESH_BITS-1:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_method     <= METHOD_CROSS;
            cfg_reg.grid_columns     <= GRID_COLUMNS_RESET;
            cfg_reg.grid_rows        <= GRID_ROWS_RESET;
            cfg_reg.nodata_threshold <= NODATA_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SLOPE_METHOD:
                prdata = APB_DATA_BITS'(cfg_reg.slope_method);
            REG_GRID_COLUMNS:
                prdata = APB_DATA_BITS'(cfg_reg.grid_columns);
            REG_GRID_ROWS:
                prdata = APB_DATA_BITS'(cfg_reg.grid_rows);
            REG_NODATA_THRESHOLD:
                prdata = APB_DATA_BITS'(cfg_reg.nodata_threshold);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dfdm_prep.sv @@
// First pipeline stage: slope differences, no-data test and border distances.
`timescale 1ns / 1ps
`default_nettype none

module dfdm_prep #(
    parameter int HEIGHT_BITS = 32,
    parameter int COORD_BITS  = 16,
    parameter int SW          = HEIGHT_BITS + 1,
    parameter int DW          = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [HEIGHT_BITS-1:0]  center,
    input  logic signed [HEIGHT_BITS-1:0]  nb [dfdm_pkg::NUM_DIRS],
    input  logic [COORD_BITS-1:0]          row,
    input  logic [COORD_BITS-1:0]          col,
    input  dfdm_pkg::cfg_t                 cfg,
    output logic                           s1_valid,
    output logic signed [SW-1:0]           s1_slope [dfdm_pkg::NUM_DIRS],
    output logic                           s1_nodata,
    output logic                           s1_dummy,
    output logic signed [DW-1:0]           s1_dn,
    output logic signed [DW-1:0]           s1_dw,
    output logic signed [DW-1:0]           s1_de,
    output logic signed [DW-1:0]           s1_ds,
    output logic                           s1_col_lo,
    output logic                           s1_row_lo
);
    import dfdm_pkg::*;

    localparam int TW = (HEIGHT_BITS > THRESH_BITS) ? HEIGHT_BITS : THRESH_BITS;
    localparam logic signed [DW-1:0] ONE = DW'(1);

    logic signed [SW-1:0] nb_ext [NUM_DIRS];
    logic signed [SW-1:0] minuend [NUM_DIRS];
    logic signed [SW-1:0] slope_next [NUM_DIRS];
    logic signed [SW-1:0] center_ext;
    logic signed [TW-1:0] center_t;
    logic signed [TW-1:0] thresh_t;
    logic signed [DW-1:0] row_s;
    logic signed [DW-1:0] col_s;
    logic signed [DW-1:0] cols_s;
    logic signed [DW-1:0] rows_s;

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [SW-1:0] slope_reg [NUM_DIRS];
    logic                 nodata_reg;
    logic                 nodata_next;
    logic                 dummy_reg;
    logic                 dummy_next;
    logic signed [DW-1:0] dn_reg;
    logic signed [DW-1:0] dn_next;
    logic signed [DW-1:0] dw_reg;
    logic signed [DW-1:0] dw_next;
    logic signed [DW-1:0] de_reg;
    logic signed [DW-1:0] de_next;
    logic signed [DW-1:0] ds_reg;
    logic signed [DW-1:0] ds_next;
    logic                 col_lo_reg;
    logic                 col_lo_next;
    logic                 row_lo_reg;
    logic                 row_lo_next;

    assign center_ext = SW'(center);

    // Every slope is one subtraction with the neighbor as subtrahend; only the
    // minuend changes with the method.
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            nb_ext[d] = SW'(nb[d]);
        end
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            case (cfg.slope_method)
                METHOD_CROSS:  minuend[d] = nb_ext[(d + 4) & (NUM_DIRS - 1)];
                METHOD_DIRECT: minuend[d] = center_ext;
                default:       minuend[d] = '0;
            endcase
            slope_next[d] = minuend[d] - nb_ext[d];
        end
    end

    assign center_t    = TW'(center);
    assign thresh_t    = TW'(cfg.nodata_threshold);
    assign nodata_next = center_t < thresh_t;
    assign dummy_next  = cfg.slope_method == METHOD_DUMMY;

    assign row_s  = $signed(DW'(row));
    assign col_s  = $signed(DW'(col));
    assign cols_s = $signed(DW'(cfg.grid_columns));
    assign rows_s = $signed(DW'(cfg.grid_rows));

    assign dn_next     = row_s;
    assign dw_next     = col_s;
    assign de_next     = cols_s - col_s - ONE;
    assign ds_next     = rows_s - row_s - ONE;
    assign col_lo_next = col_s < (cols_s >>> 1);
    assign row_lo_next = row_s < (rows_s >>> 1);
    assign valid_next  = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            slope_reg[d] <= slope_next[d];
        end
        nodata_reg <= nodata_next;
        dummy_reg  <= dummy_next;
        dn_reg     <= dn_next;
        dw_reg     <= dw_next;
        de_reg     <= de_next;
        ds_reg     <= ds_next;
        col_lo_reg <= col_lo_next;
        row_lo_reg <= row_lo_next;
    end

    assign s1_valid  = valid_reg;
    assign s1_slope  = slope_reg;
    assign s1_nodata = nodata_reg;
    assign s1_dummy  = dummy_reg;
    assign s1_dn     = dn_reg;
    assign s1_dw     = dw_reg;
    assign s1_de     = de_reg;
    assign s1_ds     = ds_reg;
    assign s1_col_lo = col_lo_reg;
    assign s1_row_lo = row_lo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dfdm_select.sv @@
// Pipeline stages two to four: border mask, registered maximum tree, final mask.
`timescale 1ns / 1ps
`default_nettype none

module dfdm_select #(
    parameter int SW = 33,
    parameter int DW = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  logic signed [SW-1:0]  s1_slope [dfdm_pkg::NUM_DIRS],
    input  logic                  s1_nodata,
    input  logic                  s1_dummy,
    input  logic signed [DW-1:0]  s1_dn,
    input  logic signed [DW-1:0]  s1_dw,
    input  logic signed [DW-1:0]  s1_de,
    input  logic signed [DW-1:0]  s1_ds,
    input  logic                  s1_col_lo,
    input  logic                  s1_row_lo,
    output logic                  done,
    output logic [7:0]            direction_mask,
    output logic                  border_rule_used
);
    import dfdm_pkg::*;

    localparam int PAIRS = NUM_DIRS / 2;
    localparam int QUADS = NUM_DIRS / 4;

    // Stage two.
    logic                 s2_valid_reg;
    logic signed [SW-1:0] s2_slope_reg [NUM_DIRS];
    logic signed [SW-1:0] s2_max_reg [PAIRS];
    logic signed [SW-1:0] s2_max_next [PAIRS];
    logic [NUM_DIRS-1:0]  s2_bmask_reg;
    logic [NUM_DIRS-1:0]  s2_bmask_next;
    logic                 s2_nodata_reg;
    logic                 s2_dummy_reg;

    // Stage three.
    logic                 s3_valid_reg;
    logic signed [SW-1:0] s3_slope_reg [NUM_DIRS];
    logic signed [SW-1:0] s3_max_reg [QUADS];
    logic signed [SW-1:0] s3_max_next [QUADS];
    logic [NUM_DIRS-1:0]  s3_bmask_reg;
    logic                 s3_nodata_reg;
    logic                 s3_dummy_reg;

    // Stage four, the result register.
    logic signed [SW-1:0] max_all;
    logic [NUM_DIRS-1:0]  slope_mask;
    logic                 done_reg;
    logic [NUM_DIRS-1:0]  mask_reg;
    logic [NUM_DIRS-1:0]  mask_next;
    logic                 used_reg;
    logic                 used_next;

    always_comb
    begin
        for (int k = 0; k < PAIRS; k++)
        begin
            s2_max_next[k] = (s1_slope[2*k+1] > s1_slope[2*k]) ?
                             s1_slope[2*k+1] : s1_slope[2*k];
        end
    end

    always_comb
    begin
        s2_bmask_next         = '0;
        s2_bmask_next[DIR_N]  = (s1_dn < s1_dw) && (s1_dn < s1_de);
        s2_bmask_next[DIR_S]  = (s1_ds < s1_dw) && (s1_ds < s1_de);
        s2_bmask_next[DIR_W]  = (s1_dw < s1_dn) && (s1_dw < s1_ds);
        s2_bmask_next[DIR_E]  = (s1_de < s1_dn) && (s1_de < s1_ds);
        s2_bmask_next[DIR_NW] = (s1_dn == s1_dw) && s1_col_lo;
        s2_bmask_next[DIR_SE] = (s1_ds == s1_de) && !s1_col_lo;
        s2_bmask_next[DIR_SW] = (s1_ds == s1_dw) && !s1_row_lo;
        s2_bmask_next[DIR_NE] = (s1_dn == s1_de) && s1_row_lo;
    end

    always_comb
    begin
        for (int k = 0; k < QUADS; k++)
        begin
            s3_max_next[k] = (s2_max_reg[2*k+1] > s2_max_reg[2*k]) ?
                             s2_max_reg[2*k+1] : s2_max_reg[2*k];
        end
    end

    assign max_all = (s3_max_reg[1] > s3_max_reg[0]) ? s3_max_reg[1] : s3_max_reg[0];

    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            slope_mask[d] = s3_slope_reg[d] == max_all;
        end
    end

    always_comb
    begin
        used_next = 1'b0;
        if (s3_nodata_reg && (s3_bmask_reg != '0))
        begin
            mask_next = s3_bmask_reg;
            used_next = 1'b1;
        end
        else if (s3_dummy_reg)
        begin
            mask_next        = '0;
            mask_next[DIR_S] = 1'b1;
        end
        else
        begin
            mask_next = slope_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_slope_reg  <= s1_slope;
        s2_max_reg    <= s2_max_next;
        s2_bmask_reg  <= s2_bmask_next;
        s2_nodata_reg <= s1_nodata;
        s2_dummy_reg  <= s1_dummy;

        s3_slope_reg  <= s2_slope_reg;
        s3_max_reg    <= s3_max_next;
        s3_bmask_reg  <= s2_bmask_reg;
        s3_nodata_reg <= s2_nodata_reg;
        s3_dummy_reg  <= s2_dummy_reg;

        mask_reg      <= mask_next;
        used_reg      <= used_next;
    end

    assign done             = done_reg;
    assign direction_mask   = mask_reg;
    assign border_rule_used = used_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dem_flow_direction_mask_core.sv @@
// Top level of the D8 flow-direction mask block.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one elevation cell per clock and returns the 8-bit mask of
// the directions in which flow leaves it, bit 0 north and then clockwise to
// bit 7 northwest. An item is taken at any rising edge where start is high;
// busy is always low because the four-stage pipeline never stalls. The result
// is driven from the result register of the last stage and is marked by done for a
// single cycle. It must be captured at the fourth rising edge after the
// accepting one, since the receiver cannot hold it off. Items may be issued on
// every clock, so the sustained rate is one item per cycle, set by the pipeline
// stages: the slope subtractions and border
// distances, then the border compares with the first level of the maximum
// tree, then the second level, and finally the last compare with the equality
// match. A cell below the no-data threshold first tries the nearest-border
// rule; when that rule yields no direction, or the cell holds valid data, the
// slope rule of the configured method decides and border_rule_used is low.
// The configuration registers sit at byte addresses 0 (slope method),
// 4 (grid columns), 8 (grid rows) and 12 (no-data threshold, signed Q24.8),
// and should only be written while no item is in flight.

module dem_flow_direction_mask_core #(
    parameter int HEIGHT_BITS = 32,
    parameter int COORD_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    output logic                                 done,
    input  logic signed [HEIGHT_BITS-1:0]        center_height,
    input  logic signed [HEIGHT_BITS-1:0]        height_n,
    input  logic signed [HEIGHT_BITS-1:0]        height_ne,
    input  logic signed [HEIGHT_BITS-1:0]        height_e,
    input  logic signed [HEIGHT_BITS-1:0]        height_se,
    input  logic signed [HEIGHT_BITS-1:0]        height_s,
    input  logic signed [HEIGHT_BITS-1:0]        height_sw,
    input  logic signed [HEIGHT_BITS-1:0]        height_w,
    input  logic signed [HEIGHT_BITS-1:0]        height_nw,
    input  logic [COORD_BITS-1:0]                cell_row,
    input  logic [COORD_BITS-1:0]                cell_col,
    output logic [7:0]                           direction_mask,
    output logic                                 border_rule_used,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dfdm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [dfdm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [dfdm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import dfdm_pkg::*;

    // Slopes need one bit beyond the heights; distances may go negative when
    // a coordinate lies outside the configured grid.
    localparam int SW = HEIGHT_BITS + 1;
    localparam int DW = ((COORD_BITS > GRID_BITS) ? COORD_BITS : GRID_BITS) + 2;

    cfg_t                    cfg;
    logic                    accept;
    logic signed [HEIGHT_BITS-1:0] nb [NUM_DIRS];

    logic                    s1_valid;
    logic signed [SW-1:0]    s1_slope [NUM_DIRS];
    logic                    s1_nodata;
    logic                    s1_dummy;
    logic signed [DW-1:0]    s1_dn;
    logic signed [DW-1:0]    s1_dw;
    logic signed [DW-1:0]    s1_de;
    logic signed [DW-1:0]    s1_ds;
    logic                    s1_col_lo;
    logic                    s1_row_lo;

    // The pipeline accepts an item every cycle, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Neighbors in direction order, north first and then clockwise.
    assign nb[DIR_N]  = height_n;
    assign nb[DIR_NE] = height_ne;
    assign nb[DIR_E]  = height_e;
    assign nb[DIR_SE] = height_se;
    assign nb[DIR_S]  = height_s;
    assign nb[DIR_SW] = height_sw;
    assign nb[DIR_W]  = height_w;
    assign nb[DIR_NW] = height_nw;

    dfdm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfdm_prep #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .COORD_BITS  (COORD_BITS),
        .SW          (SW),
        .DW          (DW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .center    (center_height),
        .nb        (nb),
        .row       (cell_row),
        .col       (cell_col),
        .cfg       (cfg),
        .s1_valid  (s1_valid),
        .s1_slope  (s1_slope),
        .s1_nodata (s1_nodata),
        .s1_dummy  (s1_dummy),
        .s1_dn     (s1_dn),
        .s1_dw     (s1_dw),
        .s1_de     (s1_de),
        .s1_ds     (s1_ds),
        .s1_col_lo (s1_col_lo),
        .s1_row_lo (s1_row_lo)
    );

    dfdm_select #(
        .SW (SW),
        .DW (DW)
    ) u_select (
        .clk              (clk),
        .rst_n            (rst_n),
        .s1_valid         (s1_valid),
        .s1_slope         (s1_slope),
        .s1_nodata        (s1_nodata),
        .s1_dummy         (s1_dummy),
        .s1_dn            (s1_dn),
        .s1_dw            (s1_dw),
        .s1_de            (s1_de),
        .s1_ds            (s1_ds),
        .s1_col_lo        (s1_col_lo),
        .s1_row_lo        (s1_row_lo),
        .done             (done),
        .direction_mask   (direction_mask),
        .border_rule_used (border_rule_used)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dfdm_checker.sv @@
// Port-level assertions for the flow-direction mask block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dfdm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [7:0]                          direction_mask,
    input  logic                                border_rule_used,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [dfdm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dfdm_pkg::APB_DATA_BITS-1:0]  pwdata
);
    import dfdm_pkg::*;

    logic [PIPE_DEPTH-1:0] accept_hist_reg;
    logic [PIPE_DEPTH-1:0] accept_hist_next;
    slope_method_t         method_reg;
    slope_method_t         method_next;
    logic                  method_wr;

    assign accept_hist_next = {accept_hist_reg[PIPE_DEPTH-2:0], start && !busy};
    assign method_wr = psel && penable && pwrite && pready &&
                       (reg_index_t'(paddr[APB_ADDR_BITS-1:2]) == REG_SLOPE_METHOD);
    assign method_next = method_wr ? slope_method_t'(pwdata[1:0]) : method_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_hist_reg <= '0;
            method_reg      <= METHOD_CROSS;
        end
        else
        begin
            accept_hist_reg <= accept_hist_next;
            method_reg      <= method_next;
        end
    end

    // Every accepted item yields exactly one result after the fixed latency.
    a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        done == accept_hist_reg[PIPE_DEPTH-1])
        else $error("result strobe does not match an accepted item");

    // Either rule always produces at least one direction.
    a_mask_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (direction_mask != 8'h00))
        else $error("empty direction mask delivered");

    // The dummy method sends every slope-rule cell south.
    a_dummy_south: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !border_rule_used && (method_reg == METHOD_DUMMY))
        |-> (direction_mask == 8'h10))
        else $error("dummy method gave a mask other than south");

    // The configuration port completes every access without wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("configuration access stalled");

endmodule

bind dem_flow_direction_mask_core dfdm_checker u_dfdm_checker (.*);

`default_nettype wire
